### rtl/assert_macros.svh
// Assertion macros used by the double-ended queue RTL file.
// Depends on nothing; the including module must provide clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never hold at a rising clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### rtl/dq_pkg.sv
// Package for the double-ended queue: request and status codes, default sizes.
// Depends on nothing.
package dq_pkg;

    localparam int DEPTH_DEF     = 256;
    localparam int WORD_BITS_DEF = 32;
    localparam int OUT_BITS      = 32;

    typedef enum logic [2:0] {
        REQ_PUSH_BACK  = 3'd0,
        REQ_PUSH_FRONT = 3'd1,
        REQ_POP_BACK   = 3'd2,
        REQ_POP_FRONT  = 3'd3,
        REQ_NOP        = 3'd4
    } req_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_POP_EMPTY = 2'd1,
        ST_PUSH_FULL = 2'd2
    } status_t;

endpackage

### rtl/double_ended_queue.sv
// Each item passes through three steps: accept with slot write and front read, back read, result load.
// The two reads go through the single read port, and a new item is accepted only once the
// result of the item before it has loaded into the output register.
// The result loads into an output register, so the next item is accepted while it waits;
// a result still held there when the next one is ready stalls the input until it is taken.
// Reset clears head, count, state and output valid; slot contents are not cleared.
`include "assert_macros.svh"

module double_ended_queue #(
    parameter int DEPTH     = dq_pkg::DEPTH_DEF,
    parameter int WORD_BITS = dq_pkg::WORD_BITS_DEF,
    parameter int ADDR_W    = $clog2(DEPTH),
    parameter int CNT_W     = $clog2(DEPTH + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2:0]          req_type,
    input  logic signed [31:0]  value,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [31:0]  front_value,
    output logic signed [31:0]  back_value,
    output logic                is_empty,
    output logic [CNT_W-1:0]    item_count,
    output logic [1:0]          status
);

    localparam int SUM_W = CNT_W + 1;
    localparam int OUT_W = dq_pkg::OUT_BITS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_BACK,
        S_DONE
    } state_t;

    state_t                state_reg;
    logic [ADDR_W-1:0]     head_reg;
    logic [CNT_W-1:0]      count_reg;
    dq_pkg::status_t       status_reg;
    logic                  fwd_reg;
    logic [WORD_BITS-1:0]  word_reg;
    logic [WORD_BITS-1:0]  front_reg;
    logic [WORD_BITS-1:0]  rd_data_reg;
    logic                  out_valid_reg;
    logic [OUT_W-1:0]      front_out_reg;
    logic [OUT_W-1:0]      back_out_reg;
    logic                  empty_out_reg;
    logic [CNT_W-1:0]      count_out_reg;
    dq_pkg::status_t       status_out_reg;

    logic [WORD_BITS-1:0]  slots_mem [DEPTH];

    logic                  accept;
    logic                  full;
    logic [ADDR_W-1:0]     head_dec;
    logic [ADDR_W-1:0]     head_inc;
    logic [SUM_W-1:0]      pb_sum;
    logic [ADDR_W-1:0]     pb_addr;
    logic [CNT_W-1:0]      back_off;
    logic [SUM_W-1:0]      bk_sum;
    logic [ADDR_W-1:0]     back_addr;
    logic [ADDR_W-1:0]     head_next;
    logic [CNT_W-1:0]      count_next;
    dq_pkg::status_t       status_next;
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic                  mem_re;
    logic [ADDR_W-1:0]     mem_raddr;
    logic [WORD_BITS-1:0]  in_word;
    logic [WORD_BITS-1:0]  front_word;
    logic [OUT_W-1:0]      front_out;
    logic [OUT_W-1:0]      back_out;
    logic                  load_out;

    for (genvar i = 0; i < WORD_BITS; i++)
    begin : g_in_word
        if (i < OUT_W)
        begin : g_bit
            assign in_word[i] = value[i];
        end
        else
        begin : g_zero
            assign in_word[i] = 1'b0;
        end
    end

    for (genvar i = 0; i < OUT_W; i++)
    begin : g_out_word
        if (i < WORD_BITS)
        begin : g_bit
            assign front_out[i] = front_reg[i];
            assign back_out[i]  = rd_data_reg[i];
        end
        else
        begin : g_zero
            assign front_out[i] = 1'b0;
            assign back_out[i]  = 1'b0;
        end
    end

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign full     = (count_reg == CNT_W'(DEPTH));

    assign head_dec = (head_reg == ADDR_W'(0)) ? ADDR_W'(DEPTH - 1) : head_reg - ADDR_W'(1);
    assign head_inc = (head_reg == ADDR_W'(DEPTH - 1)) ? ADDR_W'(0) : head_reg + ADDR_W'(1);

    assign pb_sum  = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign pb_addr = (pb_sum >= SUM_W'(DEPTH)) ? ADDR_W'(pb_sum - SUM_W'(DEPTH))
                                                : ADDR_W'(pb_sum);

    assign back_off  = (count_reg == CNT_W'(0)) ? CNT_W'(0) : count_reg - CNT_W'(1);
    assign bk_sum    = SUM_W'(head_reg) + SUM_W'(back_off);
    assign back_addr = (bk_sum >= SUM_W'(DEPTH)) ? ADDR_W'(bk_sum - SUM_W'(DEPTH))
                                                  : ADDR_W'(bk_sum);

    always_comb
    begin
        head_next   = head_reg;
        count_next  = count_reg;
        status_next = dq_pkg::ST_OK;
        mem_we      = 1'b0;
        mem_waddr   = pb_addr;
        case (req_type)
            dq_pkg::REQ_PUSH_BACK:
            begin
                if (full)
                begin
                    status_next = dq_pkg::ST_PUSH_FULL;
                end
                else
                begin
                    mem_we     = accept;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            dq_pkg::REQ_PUSH_FRONT:
            begin
                mem_waddr = head_dec;
                if (full)
                begin
                    status_next = dq_pkg::ST_PUSH_FULL;
                end
                else
                begin
                    mem_we     = accept;
                    head_next  = head_dec;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            dq_pkg::REQ_POP_BACK:
            begin
                if (count_reg == CNT_W'(0))
                begin
                    status_next = dq_pkg::ST_POP_EMPTY;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            dq_pkg::REQ_POP_FRONT:
            begin
                if (count_reg == CNT_W'(0))
                begin
                    status_next = dq_pkg::ST_POP_EMPTY;
                end
                else
                begin
                    head_next  = head_inc;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            default:
            begin
                status_next = dq_pkg::ST_OK;
            end
        endcase
    end

    assign mem_re     = accept || (state_reg == S_BACK);
    assign mem_raddr  = (state_reg == S_IDLE) ? head_next : back_addr;
    assign front_word = fwd_reg ? word_reg : rd_data_reg;
    assign load_out   = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slots_mem[mem_waddr] <= in_word;
        end
        if (mem_re)
        begin
            rd_data_reg <= slots_mem[mem_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg <= in_word;
        end
        if (state_reg == S_BACK)
        begin
            front_reg <= front_word;
        end
        if (load_out)
        begin
            front_out_reg <= (count_reg == CNT_W'(0)) ? '0 : front_out;
            back_out_reg  <= (count_reg == CNT_W'(0)) ? '0 : back_out;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            head_reg       <= '0;
            count_reg      <= '0;
            status_reg     <= dq_pkg::ST_OK;
            fwd_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            empty_out_reg  <= 1'b1;
            count_out_reg  <= '0;
            status_out_reg <= dq_pkg::ST_OK;
        end
        else
        begin
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        head_reg   <= head_next;
                        count_reg  <= count_next;
                        status_reg <= status_next;
                        fwd_reg    <= mem_we && (mem_waddr == head_next);
                        state_reg  <= S_BACK;
                    end
                end
                S_BACK:
                begin
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (load_out)
                    begin
                        empty_out_reg  <= (count_reg == CNT_W'(0));
                        count_out_reg  <= count_reg;
                        status_out_reg <= status_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign front_value = front_out_reg;
    assign back_value  = back_out_reg;
    assign is_empty    = empty_out_reg;
    assign item_count  = count_out_reg;
    assign status      = status_out_reg;

    `ASSERT_NEVER(a_count_bound, count_reg > CNT_W'(DEPTH), "count exceeds depth")
    `ASSERT_CLK(a_count_step,
                accept |=> (count_reg == $past(count_reg)
                            || count_reg == $past(count_reg) + CNT_W'(1)
                            || count_reg == $past(count_reg) - CNT_W'(1)),
                "count moved by more than one")
    `ASSERT_CLK(a_empty_flag,
                out_valid_reg |-> (empty_out_reg == (count_out_reg == CNT_W'(0))),
                "empty flag disagrees with count")
    `ASSERT_CLK(a_full_status,
                (out_valid_reg && status_out_reg == dq_pkg::ST_PUSH_FULL)
                    |-> (count_out_reg == CNT_W'(DEPTH)),
                "push rejected while not full")
    `ASSERT_CLK(a_pop_status,
                (out_valid_reg && status_out_reg == dq_pkg::ST_POP_EMPTY) |-> empty_out_reg,
                "pop rejected while not empty")

endmodule

### tb/double_ended_queue_tb.sv
// Testbench for double_ended_queue: drives push, pop and no-op requests and checks
// each result against a ring-buffer predictor kept in the testbench.
// Depends on dq_pkg and the double_ended_queue RTL.
module double_ended_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_SIZE  = dq_pkg::DEPTH_DEF;
    localparam int ADDR_BITS  = $clog2(dq_pkg::DEPTH_DEF);
    localparam int CNT_BITS   = $clog2(dq_pkg::DEPTH_DEF + 1);
    localparam int IDLE_LIMIT = 2000;
    localparam int SETTLE     = 12;
    localparam int MAX_GAP    = 20;

    typedef struct {
        logic signed [31:0]  front;
        logic signed [31:0]  back;
        logic                empty;
        logic [CNT_BITS-1:0] count;
        dq_pkg::status_t     st;
    } deque_view_t;

    logic                clk;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    logic [2:0]          req_type  = dq_pkg::REQ_NOP;
    logic signed [31:0]  value     = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic signed [31:0]  front_value;
    logic signed [31:0]  back_value;
    logic                is_empty;
    logic [CNT_BITS-1:0] item_count;
    logic [1:0]          status;

    logic signed [31:0]  ring_words [RING_SIZE];
    logic [ADDR_BITS-1:0] ring_head = '0;
    int                  ring_count = 0;
    deque_view_t         expected_views [$];
    deque_view_t         oldest_view;
    int                  send_idle_pct  = 0;
    int                  recv_stall_pct = 0;
    int                  errors         = 0;
    int                  quiet_cycles   = 0;

    double_ended_queue u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .value       (value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .front_value (front_value),
        .back_value  (back_value),
        .is_empty    (is_empty),
        .item_count  (item_count),
        .status      (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic deque_view_t predict_deque_view(input logic [2:0] rt,
                                                       input logic signed [31:0] word);
        deque_view_t v;
        v.st = dq_pkg::ST_OK;
        if (rt == dq_pkg::REQ_PUSH_BACK || rt == dq_pkg::REQ_PUSH_FRONT)
        begin
            if (ring_count >= RING_SIZE)
            begin
                v.st = dq_pkg::ST_PUSH_FULL;
            end
            else
            begin
                if (rt == dq_pkg::REQ_PUSH_BACK)
                begin
                    ring_words[ADDR_BITS'(ring_head + ring_count)] = word;
                end
                else
                begin
                    ring_head = ring_head - 1'b1;
                    ring_words[ring_head] = word;
                end
                ring_count++;
            end
        end
        else if (rt == dq_pkg::REQ_POP_BACK || rt == dq_pkg::REQ_POP_FRONT)
        begin
            if (ring_count == 0)
            begin
                v.st = dq_pkg::ST_POP_EMPTY;
            end
            else
            begin
                if (rt == dq_pkg::REQ_POP_FRONT)
                begin
                    ring_head = ring_head + 1'b1;
                end
                ring_count--;
            end
        end
        v.empty = (ring_count == 0);
        v.front = v.empty ? 32'sd0 : ring_words[ring_head];
        v.back  = v.empty ? 32'sd0 : ring_words[ADDR_BITS'(ring_head + ring_count - 1)];
        v.count = CNT_BITS'(ring_count);
        return v;
    endfunction

    function automatic logic signed [31:0] pick_word();
        logic signed [31:0] w;
        case ($urandom_range(0, 11))
            0:       w = 32'h7FFF_FFFF;
            1:       w = 32'h8000_0000;
            2:       w = 32'h0000_0000;
            3:       w = 32'hFFFF_FFFF;
            default: w = $urandom;
        endcase
        return w;
    endfunction

    task automatic send_request(input logic [2:0] rt, input logic signed [31:0] word);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= rt;
        value    <= word;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        expected_views.insert(expected_views.size(), predict_deque_view(rt, word));
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_views.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic test_directed();
        send_request(dq_pkg::REQ_NOP, $urandom);
        send_request(dq_pkg::REQ_POP_BACK, $urandom);
        send_request(dq_pkg::REQ_POP_FRONT, $urandom);
        send_request(3'd5, $urandom);
        send_request(3'd6, $urandom);
        send_request(3'd7, $urandom);
        send_request(dq_pkg::REQ_PUSH_BACK, 32'h7FFF_FFFF);
        send_request(dq_pkg::REQ_PUSH_FRONT, 32'h8000_0000);
        send_request(dq_pkg::REQ_PUSH_BACK, 32'hFFFF_FFFF);
        send_request(dq_pkg::REQ_PUSH_FRONT, 32'h0000_0000);
        send_request(dq_pkg::REQ_PUSH_BACK, 32'h5555_5555);
        send_request(dq_pkg::REQ_PUSH_FRONT, 32'hAAAA_AAAA);
        send_request(dq_pkg::REQ_NOP, 32'hFFFF_FFFF);
        send_request(3'd7, 32'h8000_0000);
        send_request(dq_pkg::REQ_POP_FRONT, 32'h7FFF_FFFF);
        send_request(dq_pkg::REQ_POP_BACK, 32'hFFFF_FFFF);
        send_request(dq_pkg::REQ_POP_FRONT, $urandom);
        send_request(dq_pkg::REQ_POP_BACK, $urandom);
        send_request(dq_pkg::REQ_POP_BACK, $urandom);
        send_request(dq_pkg::REQ_POP_FRONT, $urandom);
        send_request(dq_pkg::REQ_POP_FRONT, $urandom);
        send_request(dq_pkg::REQ_PUSH_FRONT, 32'h0000_0001);
        send_request(dq_pkg::REQ_POP_BACK, $urandom);
    endtask

    task automatic test_full_and_wrap();
        while (ring_count < RING_SIZE)
        begin
            send_request($urandom_range(0, 1) ? dq_pkg::REQ_PUSH_FRONT : dq_pkg::REQ_PUSH_BACK,
                         pick_word());
        end
        send_request(dq_pkg::REQ_PUSH_BACK, pick_word());
        send_request(dq_pkg::REQ_PUSH_FRONT, pick_word());
        send_request(dq_pkg::REQ_NOP, pick_word());
        send_request(dq_pkg::REQ_POP_FRONT, pick_word());
        send_request(dq_pkg::REQ_PUSH_FRONT, pick_word());
        send_request(dq_pkg::REQ_PUSH_BACK, pick_word());
        send_request(dq_pkg::REQ_POP_BACK, pick_word());
        send_request(dq_pkg::REQ_PUSH_BACK, pick_word());
        while (ring_count > 0)
        begin
            send_request($urandom_range(0, 1) ? dq_pkg::REQ_POP_FRONT : dq_pkg::REQ_POP_BACK,
                         pick_word());
        end
        send_request(dq_pkg::REQ_POP_FRONT, pick_word());
    endtask

    task automatic test_random(input int n_items);
        int burst_left;
        int push_pct;
        int r;
        logic [2:0] rt;
        burst_left = 0;
        push_pct   = 50;
        for (int i = 0; i < n_items; i++)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(20, 120);
                case ($urandom_range(0, 2))
                    0:       push_pct = 90;
                    1:       push_pct = 50;
                    default: push_pct = 10;
                endcase
            end
            burst_left--;
            if (i == n_items / 2)
            begin
                wait_for_results();
            end
            r = $urandom_range(0, 99);
            if (r < 5)
            begin
                rt = 3'($urandom_range(4, 7));
            end
            else if ($urandom_range(0, 99) < push_pct)
            begin
                rt = $urandom_range(0, 1) ? dq_pkg::REQ_PUSH_FRONT : dq_pkg::REQ_PUSH_BACK;
            end
            else
            begin
                rt = $urandom_range(0, 1) ? dq_pkg::REQ_POP_FRONT : dq_pkg::REQ_POP_BACK;
            end
            send_request(rt, pick_word());
        end
    endtask

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_views.size() == 0)
            begin
                $error("unexpected result: no request is pending");
                errors++;
            end
            else
            begin
                oldest_view = expected_views[0];
                expected_views.delete(0);
                if (front_value !== oldest_view.front)
                begin
                    $error("front_value: expected %0d, actual %0d", oldest_view.front,
                           front_value);
                    errors++;
                end
                if (back_value !== oldest_view.back)
                begin
                    $error("back_value: expected %0d, actual %0d", oldest_view.back,
                           back_value);
                    errors++;
                end
                if (is_empty !== oldest_view.empty)
                begin
                    $error("is_empty: expected %0d, actual %0d", oldest_view.empty, is_empty);
                    errors++;
                end
                if (item_count !== oldest_view.count)
                begin
                    $error("item_count: expected %0d, actual %0d", oldest_view.count,
                           item_count);
                    errors++;
                end
                if (status !== oldest_view.st)
                begin
                    $error("status: expected %0d, actual %0d", oldest_view.st, status);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct  = 35;
        recv_stall_pct = 67;
        test_directed();
        test_full_and_wrap();
        test_random(220);

        send_idle_pct  = 67;
        recv_stall_pct = 35;
        test_random(220);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random(220);

        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_views.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
        if (errors == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/dq_pkg.sv
rtl/double_ended_queue.sv
tb/double_ended_queue_tb.sv
